// File: rtl/pxau_pkg.sv
// Package of the pixel arithmetic unit.
// Holds widths, operation codes and register indexes; depends on nothing.
`default_nettype none

package pxau_pkg;

  // Default width of one pixel channel.
  localparam int unsigned PXAU_PIXEL_BITS = 8;

  // Configuration port and register widths.
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 8;
  localparam int unsigned MODE_BITS      = 3;
  localparam int unsigned COEF_BITS      = 8;

  // Operation selected by the mode register.
  typedef enum logic [MODE_BITS-1:0] {
    MODE_ADD     = 3'd0,
    MODE_SUB     = 3'd1,
    MODE_COMPL   = 3'd2,
    MODE_DIV     = 3'd3,
    MODE_MUL     = 3'd4,
    MODE_LIN     = 3'd5,
    MODE_ABSDIFF = 3'd6,
    MODE_BLACK   = 3'd7
  } mode_e;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE        = 3'd0,
    REG_DIVISOR     = 3'd1,
    REG_GAIN        = 3'd2,
    REG_COEF_FIRST  = 3'd3,
    REG_COEF_SECOND = 3'd4
  } reg_index_e;

endpackage

`default_nettype wire

// File: rtl/pxau_if.sv
// Stream and configuration interfaces of the pixel arithmetic unit.
// Depends on pxau_pkg for the default pixel width and register port widths.
`default_nettype none

// Input channel: one pixel pair per transfer.
interface pxau_pixel_in_if
  import pxau_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = PXAU_PIXEL_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_first;
  logic [PIXEL_BITS-1:0] pixel_second;

  modport source (output valid, output pixel_first, output pixel_second, input ready);
  modport sink   (input valid, input pixel_first, input pixel_second, output ready);
endinterface

// Output channel: one result pixel per transfer.
interface pxau_pixel_out_if
  import pxau_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = PXAU_PIXEL_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

// Configuration write channel.
interface pxau_cfg_if
  import pxau_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/pxau_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on pxau_pkg for the divisor width.
`default_nettype none

module pxau_divider
  import pxau_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = PXAU_PIXEL_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic [PIXEL_BITS-1:0]    en_i,
  input  wire logic [PIXEL_BITS-1:0]    dividend_i,
  input  wire logic [CFG_DATA_BITS-1:0] divisor_i,
  output logic      [PIXEL_BITS-1:0]    quotient_o
);

  // Partial remainder stays below twice the divisor.
  localparam int unsigned REM_BITS = CFG_DATA_BITS + 1;
  localparam int unsigned ACC_BITS = REM_BITS + PIXEL_BITS;

  // Each stage holds {remainder, remaining dividend bits / quotient bits}.
  logic [ACC_BITS-1:0] acc_q [PIXEL_BITS];

  for (genvar k = 0; k < PIXEL_BITS; k++) begin : g_stage
    logic [ACC_BITS-1:0] acc_in;
    logic [ACC_BITS-1:0] acc_sh;
    logic [REM_BITS:0]   trial;
    logic [ACC_BITS-1:0] acc_d;

    if (k == 0) begin : g_first
      assign acc_in = {{REM_BITS{1'b0}}, dividend_i};
    end else begin : g_next
      assign acc_in = acc_q[k-1];
    end

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
      acc_sh = acc_in << 1;
      trial  = {1'b0, acc_sh[ACC_BITS-1:PIXEL_BITS]}
             - {{(REM_BITS+1-CFG_DATA_BITS){1'b0}}, divisor_i};
      acc_d  = acc_sh;
      if (!trial[REM_BITS]) begin
        acc_d = {trial[REM_BITS-1:0], acc_sh[PIXEL_BITS-1:1], 1'b1};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        acc_q[k] <= acc_d;
      end
    end
  end

  assign quotient_o = acc_q[PIXEL_BITS-1][PIXEL_BITS-1:0];

endmodule

`default_nettype wire

// File: rtl/pixel_arithmetic_unit.sv
// Pixel arithmetic unit: saturating point operations on two pixel streams.
// Depends on pxau_pkg, the interfaces in pxau_if and pxau_divider.
//
// The unit takes one pixel pair per clock while the output is not stalled and
// returns one clamped pixel per pair. The pipeline depth is set by the divider,
// which resolves one quotient bit per pipeline stage; all other operations
// travel through matching stages so results leave in order. Every stage has its
// own valid bit, so empty stages fill while the output waits and a full pipeline
// holds without loss. Register writes take effect at once and should be made
// only while the unit is empty. Mode 7 gives black, negative results give 0 and
// overflows give the maximum.
`default_nettype none

module pixel_arithmetic_unit
  import pxau_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = PXAU_PIXEL_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pxau_pixel_in_if.sink    pix_in,
  pxau_pixel_out_if.source pix_out,
  pxau_cfg_if.sink         cfg
);

  localparam int unsigned PROD_BITS = PIXEL_BITS + COEF_BITS + 1;
  localparam int unsigned RES_BITS  = PROD_BITS + 1;
  localparam int unsigned LAST      = PIXEL_BITS + 1;
  localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = {PIXEL_BITS{1'b1}};

  // Configuration registers.
  mode_e                     mode_q;
  logic [CFG_DATA_BITS-1:0]  divisor_q;
  logic [COEF_BITS-1:0]      gain_q;
  logic [COEF_BITS-1:0]      coef_first_q;
  logic [COEF_BITS-1:0]      coef_second_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_ADD;
      divisor_q     <= CFG_DATA_BITS'(1);
      gain_q        <= COEF_BITS'(1);
      coef_first_q  <= COEF_BITS'(1);
      coef_second_q <= COEF_BITS'(1);
    end else if (cfg.valid) begin
      case (reg_index_e'(cfg.index))
        REG_MODE:        mode_q        <= mode_e'(cfg.data[MODE_BITS-1:0]);
        REG_DIVISOR:     divisor_q     <= cfg.data;
        REG_GAIN:        gain_q        <= cfg.data[COEF_BITS-1:0];
        REG_COEF_FIRST:  coef_first_q  <= cfg.data[COEF_BITS-1:0];
        REG_COEF_SECOND: coef_second_q <= cfg.data[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Per-stage valid bits and load enables; a stage loads when it is empty
  // or when the stage after it moves.
  logic [LAST:0] valid_q;
  logic [LAST:0] en;

  always_comb begin
    en[LAST] = !valid_q[LAST] || pix_out.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign pix_in.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= pix_in.valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 0: capture the pixels and form the two products.
  logic [PIXEL_BITS-1:0]       a_q;
  logic [PIXEL_BITS-1:0]       b_q;
  mode_e                       mode0_q;
  logic signed [PROD_BITS-1:0] prod_a_q;
  logic signed [PROD_BITS-1:0] prod_b_q;
  logic signed [PROD_BITS-1:0] ext_a;
  logic signed [PROD_BITS-1:0] ext_b;
  logic signed [PROD_BITS-1:0] ext_wa;
  logic signed [PROD_BITS-1:0] ext_wb;
  logic [COEF_BITS-1:0]        weight_b;

  always_comb begin
    weight_b = (mode_q == MODE_MUL) ? gain_q : coef_second_q;
    ext_a    = signed'({{(PROD_BITS-PIXEL_BITS){1'b0}}, pix_in.pixel_first});
    ext_b    = signed'({{(PROD_BITS-PIXEL_BITS){1'b0}}, pix_in.pixel_second});
    ext_wa   = signed'({{(PROD_BITS-COEF_BITS){coef_first_q[COEF_BITS-1]}}, coef_first_q});
    ext_wb   = signed'({{(PROD_BITS-COEF_BITS){weight_b[COEF_BITS-1]}}, weight_b});
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_q      <= pix_in.pixel_first;
      b_q      <= pix_in.pixel_second;
      mode0_q  <= mode_q;
      prod_a_q <= ext_a * ext_wa;
      prod_b_q <= ext_b * ext_wb;
    end
  end

  // Stage 1: exact signed result of every mode but division.
  logic signed [RES_BITS-1:0] res_d;
  logic signed [RES_BITS-1:0] wa;
  logic signed [RES_BITS-1:0] wb;

  always_comb begin
    wa = signed'({{(RES_BITS-PIXEL_BITS){1'b0}}, a_q});
    wb = signed'({{(RES_BITS-PIXEL_BITS){1'b0}}, b_q});
    case (mode0_q)
      MODE_ADD:     res_d = wa + wb;
      MODE_SUB:     res_d = wa - wb;
      MODE_COMPL:   res_d = signed'({{(RES_BITS-PIXEL_BITS){1'b0}}, PIXEL_MAX}) - wb;
      MODE_MUL:     res_d = RES_BITS'(prod_b_q);
      MODE_LIN:     res_d = RES_BITS'(prod_a_q) + RES_BITS'(prod_b_q);
      MODE_ABSDIFF: res_d = (a_q >= b_q) ? (wa - wb) : (wb - wa);
      default:      res_d = '0;
    endcase
  end

  // Stages 1 to PIXEL_BITS: result and mode ride alongside the divider.
  logic signed [RES_BITS-1:0] res_q  [1:PIXEL_BITS];
  mode_e                      mode_pipe_q [1:PIXEL_BITS];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      res_q[1]       <= res_d;
      mode_pipe_q[1] <= mode0_q;
    end
    for (int k = 2; k <= PIXEL_BITS; k++) begin
      if (en[k]) begin
        res_q[k]       <= res_q[k-1];
        mode_pipe_q[k] <= mode_pipe_q[k-1];
      end
    end
  end

  logic [PIXEL_BITS-1:0] quotient;

  pxau_divider #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .en_i       (en[PIXEL_BITS:1]),
    .dividend_i (b_q),
    .divisor_i  (divisor_q),
    .quotient_o (quotient)
  );

  // Last stage: clamp to the pixel range and pick the result.
  logic [PIXEL_BITS-1:0] clamped;
  logic [PIXEL_BITS-1:0] pixel_out_d;
  logic [PIXEL_BITS-1:0] pixel_out_q;
  logic signed [RES_BITS-1:0] res_last;

  always_comb begin
    res_last = res_q[PIXEL_BITS];
    if (res_last[RES_BITS-1]) begin
      clamped = '0;
    end else if (res_last[RES_BITS-2:PIXEL_BITS] != '0) begin
      clamped = PIXEL_MAX;
    end else begin
      clamped = res_last[PIXEL_BITS-1:0];
    end
    case (mode_pipe_q[PIXEL_BITS])
      MODE_DIV:   pixel_out_d = quotient;
      MODE_BLACK: pixel_out_d = '0;
      default:    pixel_out_d = clamped;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[LAST]) begin
      pixel_out_q <= pixel_out_d;
    end
  end

  assign pix_out.valid     = valid_q[LAST];
  assign pix_out.pixel_out = pixel_out_q;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench of the pixel arithmetic unit, with random stimulus.
// It drives pixel pairs and register writes, then checks each clamped output byte.
// Depends on pxau_pkg, the pxau_if interfaces and the pixel_arithmetic_unit RTL.
`timescale 1ns / 1ps

module testbench;
  import pxau_pkg::*;

  localparam int unsigned PIX_BITS     = PXAU_PIXEL_BITS;
  localparam int          PIX_MAX      = (1 << PIX_BITS) - 1;
  localparam int unsigned IDLE_PERCENT = 23;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [CFG_INDEX_BITS-1:0] FIRST_SPARE_INDEX =
    CFG_INDEX_BITS'(REG_COEF_SECOND + 1);

  // Mirror of the unit: register copy, expected byte queue and mismatch count.
  class alu_mirror;
    mode_e                    op_mode;
    logic [CFG_DATA_BITS-1:0] divisor_reg;
    logic [CFG_DATA_BITS-1:0] gain_reg;
    logic [CFG_DATA_BITS-1:0] coef_first_reg;
    logic [CFG_DATA_BITS-1:0] coef_second_reg;
    logic [PIX_BITS-1:0]      pending_pixels[$];
    int unsigned              mismatch_count;

    function new();
      op_mode         = MODE_ADD;
      divisor_reg     = CFG_DATA_BITS'(1);
      gain_reg        = CFG_DATA_BITS'(1);
      coef_first_reg  = CFG_DATA_BITS'(1);
      coef_second_reg = CFG_DATA_BITS'(1);
      mismatch_count  = 0;
    endfunction

    // A write to an index without a register is dropped.
    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        REG_MODE:        op_mode = mode_e'(value[MODE_BITS-1:0]);
        REG_DIVISOR:     divisor_reg = value;
        REG_GAIN:        gain_reg = value;
        REG_COEF_FIRST:  coef_first_reg = value;
        REG_COEF_SECOND: coef_second_reg = value;
        default: ;
      endcase
    endfunction

    // Exact signed result of the selected operation, clamped to the pixel range.
    function logic [PIX_BITS-1:0] clamped_point_op(logic [PIX_BITS-1:0] a,
                                                   logic [PIX_BITS-1:0] b);
      int first_v;
      int second_v;
      int raw;
      first_v  = a;
      second_v = b;
      case (op_mode)
        MODE_ADD:     raw = first_v + second_v;
        MODE_SUB:     raw = first_v - second_v;
        MODE_COMPL:   raw = PIX_MAX - second_v;
        MODE_DIV:     raw = (divisor_reg == 0) ? PIX_MAX : second_v / int'(divisor_reg);
        MODE_MUL:     raw = second_v * int'($signed(gain_reg));
        MODE_LIN:     raw = int'($signed(coef_first_reg)) * first_v +
                            int'($signed(coef_second_reg)) * second_v;
        MODE_ABSDIFF: raw = (first_v >= second_v) ? first_v - second_v : second_v - first_v;
        default:      raw = 0;
      endcase
      if (raw < 0) begin
        raw = 0;
      end else if (raw > PIX_MAX) begin
        raw = PIX_MAX;
      end
      return raw[PIX_BITS-1:0];
    endfunction

    function void note_pair(logic [PIX_BITS-1:0] a, logic [PIX_BITS-1:0] b);
      pending_pixels.push_back(clamped_point_op(a, b));
    endfunction

    function void check_pixel(logic [PIX_BITS-1:0] got);
      logic [PIX_BITS-1:0] want;
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("[%0t] unexpected output pixel %0d", $realtime, got);
        end
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] pixel_out mismatch: expected %0d, actual %0d",
                     $realtime, want, got);
          end
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        steady_flow;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned cycle_count;
  alu_mirror   tracker = new();

  pxau_pixel_in_if  #(.PIXEL_BITS(PIX_BITS)) pix_in ();
  pxau_pixel_out_if #(.PIXEL_BITS(PIX_BITS)) pix_out ();
  pxau_cfg_if                                cfg ();

  pixel_arithmetic_unit #(
    .PIXEL_BITS(PIX_BITS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_in (pix_in),
    .pix_out(pix_out),
    .cfg    (cfg)
  );

  // Clock with a 12 ns period.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run guard: a stuck handshake ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output side: random back-pressure, plus long hold-offs on request.
  initial begin
    int unsigned hold_left;
    hold_left      = 0;
    hold_served    = 0;
    pix_out.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Every output transfer is checked against the oldest expected byte.
  always @(posedge clk_i) begin
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      tracker.check_pixel(pix_out.pixel_out);
    end
  end

  function automatic logic [PIX_BITS-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] rand_coef();
    case ($urandom_range(7))
      0:       return 8'h80;
      1:       return 8'h7F;
      2:       return 8'h00;
      default: return CFG_DATA_BITS'($urandom);
    endcase
  endfunction

  // Offers one pixel pair after random idle cycles; called and returns at a falling edge.
  task automatic send_pair(input logic [PIX_BITS-1:0] a, input logic [PIX_BITS-1:0] b);
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      pix_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_in.valid        <= 1'b1;
    pix_in.pixel_first  <= a;
    pix_in.pixel_second <= b;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    tracker.note_pair(a, b);
    @(negedge clk_i);
  endtask

  // Stops offering pairs and waits until every expected byte has come out.
  task automatic drain();
    pix_in.valid <= 1'b0;
    while (tracker.pending_pixels.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // One register write transfer; leaves valid high for a following write.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    tracker.set_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_BITS-1:0] mode_data,
                               input logic [CFG_DATA_BITS-1:0] divisor,
                               input logic [CFG_DATA_BITS-1:0] gain,
                               input logic [CFG_DATA_BITS-1:0] coef_first,
                               input logic [CFG_DATA_BITS-1:0] coef_second);
    write_reg(REG_MODE, mode_data);
    write_reg(REG_DIVISOR, divisor);
    write_reg(REG_GAIN, gain);
    write_reg(REG_COEF_FIRST, coef_first);
    write_reg(REG_COEF_SECOND, coef_second);
    cfg.valid <= 1'b0;
  endtask

  // Directed check of one operation with two corner pairs of the pixel range.
  task automatic directed_case(input mode_e op, input logic [CFG_DATA_BITS-1:0] divisor,
                               input logic [CFG_DATA_BITS-1:0] gain,
                               input logic [CFG_DATA_BITS-1:0] coef_first,
                               input logic [CFG_DATA_BITS-1:0] coef_second);
    drain();
    apply_setting(CFG_DATA_BITS'(op), divisor, gain, coef_first, coef_second);
    send_pair('0, '1);
    send_pair('1, '1);
  endtask

  task automatic random_setting();
    logic [CFG_DATA_BITS-1:0] divisor;
    case ($urandom_range(9))
      0:       divisor = 8'd1;
      1:       divisor = 8'd255;
      default: divisor = CFG_DATA_BITS'($urandom_range(255, 1));
    endcase
    apply_setting(CFG_DATA_BITS'($urandom), divisor, rand_coef(), rand_coef(), rand_coef());
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned count;
    steady_flow         = 1'b0;
    hold_requests       = 0;
    pix_in.valid        = 1'b0;
    pix_in.pixel_first  = '0;
    pix_in.pixel_second = '0;
    cfg.valid           = 1'b0;
    cfg.index           = '0;
    cfg.data            = '0;
    rst_ni              = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings give saturating add.
    send_pair('0, '0);
    send_pair('1, '0);
    send_pair('0, '1);
    send_pair('1, '1);
    directed_case(MODE_SUB, 8'd1, 8'd1, 8'd1, 8'd1);
    directed_case(MODE_COMPL, 8'd1, 8'd1, 8'd1, 8'd1);
    directed_case(MODE_DIV, 8'd255, 8'd1, 8'd1, 8'd1);
    // A zero divisor saturates to white.
    directed_case(MODE_DIV, 8'd0, 8'd1, 8'd1, 8'd1);
    directed_case(MODE_MUL, 8'd1, 8'h7F, 8'd1, 8'd1);
    directed_case(MODE_LIN, 8'd1, 8'd1, 8'h7F, 8'h80);
    directed_case(MODE_ABSDIFF, 8'd1, 8'd1, 8'd1, 8'd1);
    // The unused mode gives black.
    directed_case(MODE_BLACK, 8'd1, 8'd1, 8'd1, 8'd1);

    // Writes to indexes without a register must leave the settings alone.
    drain();
    for (int idx = FIRST_SPARE_INDEX; idx < (1 << CFG_INDEX_BITS); idx++) begin
      write_reg(CFG_INDEX_BITS'(idx), '1);
    end
    cfg.valid <= 1'b0;
    send_pair('1, '0);

    // Random phases, each with its own register setting.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      random_setting();
      count       = $urandom_range(60, 15);
      steady_flow = (phase == 4);
      if (steady_flow) begin
        count = 150;
      end
      // Long output hold-off while pairs keep coming, so the pipeline fills.
      if (phase == 2) begin
        hold_requests++;
        count = 80;
      end
      for (int unsigned i = 0; i < count; i++) begin
        send_pair(rand_pixel(), rand_pixel());
        // Mid-phase pause until the unit has emptied.
        if (phase == 6 && i == count / 2) begin
          drain();
        end
      end
      sent += count;
      phase++;
    end
    steady_flow = 1'b0;

    drain();
    repeat (PIX_BITS + 8) @(posedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.pending_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
